>>> src/olir_pkg.sv
// Shared types, constants and helper functions for the ordered list block.
// No dependencies; every other file refers to this package by scoped names.
package olir_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 3;
  localparam int OP_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_BACK  = 2'd1,
    OP_REMOVE    = 2'd2,
    OP_SHOW      = 2'd3
  } olir_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4,
    ST_SHOWN     = 3'd5
  } olir_status_e;

  // One result transaction as it leaves the sequencer.
  typedef struct packed {
    olir_status_e       status;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
    logic [COUNT_W-1:0] count;
    logic               last;
  } olir_res_t;

  // Request to the entry store: one write and one read address per cycle.
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [VALUE_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } olir_mem_req_t;

  // Physical slot of the entry at logical position idx of a ring starting at head.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] head,
                                                input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= (IDX_W+1)'(CAPACITY)) begin
      sum = sum - (IDX_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Slot in front of head, wrapping at the bottom of the ring.
  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] head);
    logic [IDX_W-1:0] res;
    if (head == '0) begin
      res = IDX_W'(CAPACITY - 1);
    end else begin
      res = head - IDX_W'(1);
    end
    return res;
  endfunction

endpackage

>>> src/olir_store.sv
// Entry storage: CAPACITY words, one write port and one registered read port.
// Depends on olir_pkg for widths and the request struct.
module olir_store (
  input  logic                           clk_i,
  input  olir_pkg::olir_mem_req_t        req_i,
  output logic [olir_pkg::VALUE_W-1:0]   rdata_o
);

  logic [olir_pkg::VALUE_W-1:0] mem_q [olir_pkg::CAPACITY];
  logic [olir_pkg::VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/olir_ctrl.sv
// Sequencer of the ordered list: ring pointers, fill count, shared comparator.
// Depends on olir_pkg; drives olir_store and hands results to the output stage.
module olir_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  olir_pkg::olir_op_e             in_op_i,
  input  logic [olir_pkg::VALUE_W-1:0]   in_value_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output olir_pkg::olir_res_t            res_o,
  output olir_pkg::olir_mem_req_t        mem_req_o,
  input  logic [olir_pkg::VALUE_W-1:0]   mem_rdata_i
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_INS      = 9'b000000010,
    S_SCAN_RD  = 9'b000000100,
    S_SCAN_CMP = 9'b000001000,
    S_SH_RD    = 9'b000010000,
    S_SH_WR    = 9'b000100000,
    S_SHOW_RD  = 9'b001000000,
    S_SHOW_LD  = 9'b010000000,
    S_EMIT     = 9'b100000000
  } state_e;

  state_e                         state_q, state_d;
  logic [olir_pkg::IDX_W-1:0]     head_q, head_d;
  logic [olir_pkg::CNT_W-1:0]     count_q, count_d;
  logic [olir_pkg::IDX_W-1:0]     i_q, i_d;
  logic [olir_pkg::IDX_W-1:0]     j_q, j_d;
  olir_pkg::olir_op_e             op_q, op_d;
  logic [olir_pkg::VALUE_W-1:0]   val_q, val_d;
  olir_pkg::olir_res_t            res_q, res_d;
  logic [olir_pkg::CNT_W-1:0]     i_next_cnt, j_next_cnt;
  logic [olir_pkg::IDX_W-1:0]     front_slot;

  assign i_next_cnt = olir_pkg::CNT_W'(i_q) + olir_pkg::CNT_W'(1);
  assign j_next_cnt = olir_pkg::CNT_W'(j_q) + olir_pkg::CNT_W'(1);
  assign front_slot = olir_pkg::ring_dec(head_q);

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    count_d = count_q;
    i_d     = i_q;
    j_d     = j_q;
    op_d    = op_q;
    val_d   = val_q;
    res_d   = res_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = olir_pkg::ring_add(head_q, j_q);
    mem_req_o.wdata = mem_rdata_i;
    mem_req_o.raddr = olir_pkg::ring_add(head_q, i_q);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d  = in_op_i;
          val_d = in_value_i;
          i_d   = '0;
          res_d.value = in_value_i;
          res_d.pos   = '0;
          res_d.count = olir_pkg::COUNT_W'(count_q);
          res_d.last  = 1'b1;
          case (in_op_i)
            olir_pkg::OP_INS_FRONT, olir_pkg::OP_INS_BACK: begin
              if (count_q == olir_pkg::CNT_W'(olir_pkg::CAPACITY)) begin
                res_d.status = olir_pkg::ST_FULL;
                state_d      = S_EMIT;
              end else begin
                state_d = S_INS;
              end
            end
            olir_pkg::OP_REMOVE: begin
              if (count_q == '0) begin
                res_d.status = olir_pkg::ST_EMPTY;
                state_d      = S_EMIT;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            default: begin
              if (count_q == '0) begin
                res_d.status = olir_pkg::ST_EMPTY;
                res_d.value  = '0;
                state_d      = S_EMIT;
              end else begin
                state_d = S_SHOW_RD;
              end
            end
          endcase
        end
      end

      S_INS: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.wdata = val_q;
        if (op_q == olir_pkg::OP_INS_FRONT) begin
          head_d          = front_slot;
          mem_req_o.waddr = front_slot;
          res_d.pos       = '0;
        end else begin
          mem_req_o.waddr = olir_pkg::ring_add(head_q, olir_pkg::IDX_W'(count_q));
          res_d.pos       = olir_pkg::POS_W'(count_q);
        end
        count_d      = count_q + olir_pkg::CNT_W'(1);
        res_d.status = olir_pkg::ST_INSERTED;
        res_d.count  = olir_pkg::COUNT_W'(count_d);
        state_d      = S_EMIT;
      end

      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (mem_rdata_i == val_q) begin
          j_d       = i_q;
          res_d.pos = olir_pkg::POS_W'(i_q);
          state_d   = S_SH_RD;
        end else if (i_next_cnt < count_q) begin
          i_d     = i_q + olir_pkg::IDX_W'(1);
          state_d = S_SCAN_RD;
        end else begin
          res_d.status = olir_pkg::ST_NOT_FOUND;
          state_d      = S_EMIT;
        end
      end

      // Close the gap: move each later entry down by one slot.
      S_SH_RD: begin
        mem_req_o.raddr = olir_pkg::ring_add(head_q, j_q + olir_pkg::IDX_W'(1));
        if (j_next_cnt < count_q) begin
          state_d = S_SH_WR;
        end else begin
          count_d      = count_q - olir_pkg::CNT_W'(1);
          res_d.status = olir_pkg::ST_REMOVED;
          res_d.count  = olir_pkg::COUNT_W'(count_d);
          state_d      = S_EMIT;
        end
      end

      S_SH_WR: begin
        mem_req_o.we = 1'b1;
        j_d          = j_q + olir_pkg::IDX_W'(1);
        state_d      = S_SH_RD;
      end

      S_SHOW_RD: begin
        state_d = S_SHOW_LD;
      end

      S_SHOW_LD: begin
        res_d.status = olir_pkg::ST_SHOWN;
        res_d.value  = mem_rdata_i;
        res_d.pos    = olir_pkg::POS_W'(i_q);
        res_d.count  = olir_pkg::COUNT_W'(count_q);
        res_d.last   = (i_next_cnt == count_q);
        state_d      = S_EMIT;
      end

      S_EMIT: begin
        if (res_ready_i) begin
          if (res_q.last) begin
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + olir_pkg::IDX_W'(1);
            state_d = S_SHOW_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    j_q   <= j_d;
    op_q  <= op_d;
    val_q <= val_d;
    res_q <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_EMIT);
  assign res_o       = res_q;

endmodule

>>> src/ordered_list_insert_remove.sv
// Ordered list of up to CAPACITY signed 32-bit values with front/back insert,
// remove by value and show. Remove scans from the front for the first match (not found
// once every entry is read), then moves each entry behind it down by one slot; show emits
// the entries in order, tlast on the last. A full insert, or a remove or show on an empty
// list, only reports a status. The next input is taken in the cycle after the last result
// enters the output register. Reset (rst_ni low, asynchronous) empties the list at once.
module ordered_list_insert_remove (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [31:0] value
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] operation
  // Output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // [31:0] entry_value, [35:32] entry_position,
                                       // [40:36] entry_count, [47:41] zero
  output logic [2:0]  m_axis_tuser_o,  // [2:0] status
  output logic        m_axis_tlast_o
);

  olir_pkg::olir_mem_req_t        mem_req;
  logic [olir_pkg::VALUE_W-1:0]   mem_rdata;
  logic                           res_valid;
  logic                           res_ready;
  olir_pkg::olir_res_t            res;

  // Output register: the sequencer's result waits here so the sequencer can
  // fetch the next shown entry (or take the next input) while it is stalled.
  logic                           out_valid_q;
  olir_pkg::olir_res_t            out_res_q;

  olir_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  olir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_op_i     (olir_pkg::olir_op_e'(s_axis_tuser_i)),
    .in_value_i  (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // Load when empty or when the held transaction leaves this cycle.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_res_q.count, out_res_q.pos, out_res_q.value};
  assign m_axis_tuser_o  = out_res_q.status;
  assign m_axis_tlast_o  = out_res_q.last;

endmodule

>>> src/olir_checker.sv
// Port-level checks of the ordered list block, bound to the top level.
// Depends on olir_pkg for status codes and on the top level's port list.
module olir_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  logic [4:0] out_pos;
  logic [4:0] out_count;
  logic       out_shown;

  assign out_pos   = {1'b0, m_axis_tdata_o[35:32]};
  assign out_count = m_axis_tdata_o[40:36];
  assign out_shown = (m_axis_tuser_o == olir_pkg::ST_SHOWN);

  // Status codes stay within the defined set.
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o <= olir_pkg::ST_SHOWN))
    else $error("undefined status code");

  // A shown entry lies inside the list.
  a_shown_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_shown) |-> (out_pos < out_count))
    else $error("shown position beyond fill count");

  // Every status other than a shown entry ends its item.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !out_shown) |-> m_axis_tlast_o)
    else $error("single result without last");

  // No new input is taken in the middle of a listing.
  a_show_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_shown && !m_axis_tlast_o) |-> !s_axis_tready_o)
    else $error("input accepted during a listing");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
       && $stable(m_axis_tlast_o)))
    else $error("stalled result changed");

endmodule

bind ordered_list_insert_remove olir_checker u_olir_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
